// ===== design/tlvrse_pkg.sv =====
// ----------------------------------------------------------------------------
// TLV record search engine package
// Store geometry, request codes and sequencer states.
// ----------------------------------------------------------------------------
package tlvrse_pkg;

   localparam int BLOB_BYTES = 4096;
   localparam int ADDR_W     = $clog2(BLOB_BYTES);
   localparam int LEN_W      = ADDR_W + 1;
   localparam int OFF_W      = ((LEN_W > 16) ? LEN_W : 16) + 2;
   localparam int CUR_W      = 13;
   localparam int HDR_BYTES  = 4;

   localparam logic [2:0] REQ_LOAD       = 3'd0;
   localparam logic [2:0] REQ_FIND_FIRST = 3'd1;
   localparam logic [2:0] REQ_FIND_AFTER = 3'd2;
   localparam logic [2:0] REQ_LENGTH     = 3'd3;
   localparam logic [2:0] REQ_PAYLOAD    = 3'd4;
   localparam logic [2:0] REQ_STRING     = 3'd5;
   localparam logic [2:0] REQ_VALUE      = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WCHK,
      S_HRD,
      S_HCAP,
      S_HEVAL,
      S_PRD,
      S_PCAP,
      S_DONE
   } state_type;

endpackage

// ===== design/tlv_record_search_engine.sv =====
// ----------------------------------------------------------------------------
// TLV record search engine
// Byte store of id/length/payload records with a byte-at-a-time sequencer
// for loads, record searches, payload reads and value reads.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| type, restart, byte, tag, cursor, index
//  rsp     | out       | rsp_valid/rsp_stall| status, found_cursor, length, value
//  csr     | in        | csr_valid/csr_ready| end marker id
//
//  One request is worked on at a time: req_stall stays high until the sequencer is
//  back in idle. Searches walk record headers byte by byte; find after first skips
//  its start record, and a value read then reads its payload bytes. A string check
//  scans the payload for a NUL. All reads go through the single read
//  port of the byte store. Reset clears the
//  length, end marker, sequencer and response valid, not the store contents.
//  A stalled response holds in its output register while the next transaction
//  is accepted and worked on; that one then waits in its last state.
// ----------------------------------------------------------------------------
module tlv_record_search_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_type,
   input  logic                          req_load_restart,
   input  logic [7:0]                    req_load_byte,
   input  logic [15:0]                   req_tag_id,
   input  logic signed [tlvrse_pkg::CUR_W-1:0] req_cursor,
   input  logic [15:0]                   req_byte_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic signed [tlvrse_pkg::CUR_W-1:0] rsp_found_cursor,
   output logic [15:0]                   rsp_record_length,
   output logic [63:0]                   rsp_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [15:0]                   csr_end_marker_id
);

   localparam int ADDR_W = tlvrse_pkg::ADDR_W;
   localparam int LEN_W  = tlvrse_pkg::LEN_W;
   localparam int OFF_W  = tlvrse_pkg::OFF_W;
   localparam int CUR_W  = tlvrse_pkg::CUR_W;

   tlvrse_pkg::state_type state_ff, state_in;

   logic [7:0]              mem_q [tlvrse_pkg::BLOB_BYTES];
   logic [7:0]              rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr_c;
   logic                    mem_we;

   logic [2:0]              type_ff, type_in;
   logic                    restart_ff, restart_in;
   logic [7:0]              byte_ff, byte_in;
   logic [15:0]             tag_ff, tag_in;
   logic [CUR_W-1:0]        cursor_ff, cursor_in;
   logic [15:0]             bidx_ff, bidx_in;

   logic [15:0]             end_id_ff;
   logic [LEN_W-1:0]        blob_len_ff, blob_len_in;
   logic [OFF_W-1:0]        off_ff, off_in;
   logic                    skip_ff, skip_in;
   logic [1:0]              hcnt_ff, hcnt_in;
   logic [31:0]             hdr_ff, hdr_in;
   logic [OFF_W-1:0]        pay_ptr_ff, pay_ptr_in;
   logic [15:0]             pay_cnt_ff, pay_cnt_in;

   logic                    w_status_ff, w_status_in;
   logic [CUR_W-1:0]        w_fc_ff, w_fc_in;
   logic [15:0]             w_rlen_ff, w_rlen_in;
   logic [63:0]             w_val_ff, w_val_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [CUR_W-1:0]        rsp_fc_ff, rsp_fc_in;
   logic [15:0]             rsp_rlen_ff, rsp_rlen_in;
   logic [63:0]             rsp_val_ff, rsp_val_in;

   logic [OFF_W-1:0]        len_x;
   logic [OFF_W-1:0]        cur_pos;
   logic                    cur_bad;
   logic                    hdr_fit;
   logic [OFF_W-1:0]        hdr_addr;
   logic [15:0]             rid;
   logic [15:0]             rlen;
   logic [OFF_W-1:0]        rec_end;
   logic [OFF_W-1:0]        pay_base;
   logic [OFF_W-1:0]        bidx_addr;
   logic                    b_in_range;
   logic                    val_ok;
   logic                    str_go;
   logic                    pay_last;
   logic                    walk_type;
   logic [LEN_W-1:0]        load_base;
   logic                    load_ok;
   logic                    rsp_free;

   assign len_x      = OFF_W'(blob_len_ff);
   assign cur_pos    = OFF_W'(cursor_ff[CUR_W-2:0]);
   assign cur_bad    = cursor_ff[CUR_W-1] || ((cur_pos + OFF_W'(4)) > len_x);
   assign hdr_fit    = (off_ff + OFF_W'(4)) <= len_x;
   assign hdr_addr   = off_ff + OFF_W'(hcnt_ff);
   assign rid        = hdr_ff[15:0];
   assign rlen       = hdr_ff[31:16];
   assign pay_base   = off_ff + OFF_W'(4);
   assign rec_end    = pay_base + OFF_W'(rlen);
   assign bidx_addr  = pay_base + OFF_W'(bidx_ff);
   assign b_in_range = (bidx_ff < rlen) && (bidx_addr < len_x);
   assign val_ok     = ((rlen == 16'd4) || (rlen == 16'd8)) && (rec_end <= len_x);
   assign str_go     = (pay_cnt_ff < w_rlen_ff) && (pay_ptr_ff < len_x);
   assign pay_last   = pay_cnt_ff == (w_rlen_ff - 16'd1);
   assign walk_type  = (type_ff == tlvrse_pkg::REQ_FIND_FIRST) ||
                       (type_ff == tlvrse_pkg::REQ_FIND_AFTER) ||
                       (type_ff == tlvrse_pkg::REQ_VALUE);
   assign load_base  = restart_ff ? '0 : blob_len_ff;
   assign load_ok    = load_base < LEN_W'(tlvrse_pkg::BLOB_BYTES);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rd_addr_c  = (state_ff == tlvrse_pkg::S_PRD) ? pay_ptr_ff[ADDR_W-1:0]
                                                      : hdr_addr[ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlvrse_pkg::S_IDLE: begin
            if (req_valid) state_in = tlvrse_pkg::S_DECODE;
         end
         tlvrse_pkg::S_DECODE: begin
            case (type_ff)
               tlvrse_pkg::REQ_LOAD:
                  state_in = tlvrse_pkg::S_DONE;
               tlvrse_pkg::REQ_FIND_FIRST, tlvrse_pkg::REQ_VALUE:
                  state_in = tlvrse_pkg::S_WCHK;
               tlvrse_pkg::REQ_FIND_AFTER, tlvrse_pkg::REQ_LENGTH,
               tlvrse_pkg::REQ_PAYLOAD, tlvrse_pkg::REQ_STRING:
                  state_in = cur_bad ? tlvrse_pkg::S_DONE : tlvrse_pkg::S_HRD;
               default:
                  state_in = tlvrse_pkg::S_DONE;
            endcase
         end
         tlvrse_pkg::S_WCHK: begin
            state_in = hdr_fit ? tlvrse_pkg::S_HRD : tlvrse_pkg::S_DONE;
         end
         tlvrse_pkg::S_HRD: begin
            state_in = tlvrse_pkg::S_HCAP;
         end
         tlvrse_pkg::S_HCAP: begin
            state_in = (hcnt_ff == 2'(tlvrse_pkg::HDR_BYTES - 1)) ? tlvrse_pkg::S_HEVAL
                                                                 : tlvrse_pkg::S_HRD;
         end
         tlvrse_pkg::S_HEVAL: begin
            if (walk_type) begin
               if (skip_ff) begin
                  state_in = tlvrse_pkg::S_WCHK;
               end else if (rid == end_id_ff) begin
                  state_in = tlvrse_pkg::S_DONE;
               end else if (rid == tag_ff) begin
                  state_in = ((type_ff == tlvrse_pkg::REQ_VALUE) && val_ok) ?
                             tlvrse_pkg::S_PRD : tlvrse_pkg::S_DONE;
               end else begin
                  state_in = tlvrse_pkg::S_WCHK;
               end
            end else if (type_ff == tlvrse_pkg::REQ_PAYLOAD) begin
               state_in = b_in_range ? tlvrse_pkg::S_PRD : tlvrse_pkg::S_DONE;
            end else if (type_ff == tlvrse_pkg::REQ_STRING) begin
               state_in = tlvrse_pkg::S_PRD;
            end else begin
               state_in = tlvrse_pkg::S_DONE;
            end
         end
         tlvrse_pkg::S_PRD: begin
            if ((type_ff == tlvrse_pkg::REQ_STRING) && !str_go) state_in = tlvrse_pkg::S_DONE;
            else state_in = tlvrse_pkg::S_PCAP;
         end
         tlvrse_pkg::S_PCAP: begin
            case (type_ff)
               tlvrse_pkg::REQ_STRING:
                  state_in = (rd_data_ff == 8'd0) ? tlvrse_pkg::S_DONE : tlvrse_pkg::S_PRD;
               tlvrse_pkg::REQ_VALUE:
                  state_in = pay_last ? tlvrse_pkg::S_DONE : tlvrse_pkg::S_PRD;
               default:
                  state_in = tlvrse_pkg::S_DONE;
            endcase
         end
         tlvrse_pkg::S_DONE: begin
            if (rsp_free) state_in = tlvrse_pkg::S_IDLE;
         end
         default: begin
            state_in = tlvrse_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      type_in       = type_ff;
      restart_in    = restart_ff;
      byte_in       = byte_ff;
      tag_in        = tag_ff;
      cursor_in     = cursor_ff;
      bidx_in       = bidx_ff;
      blob_len_in   = blob_len_ff;
      off_in        = off_ff;
      skip_in       = skip_ff;
      hcnt_in       = hcnt_ff;
      hdr_in        = hdr_ff;
      pay_ptr_in    = pay_ptr_ff;
      pay_cnt_in    = pay_cnt_ff;
      w_status_in   = w_status_ff;
      w_fc_in       = w_fc_ff;
      w_rlen_in     = w_rlen_ff;
      w_val_in      = w_val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_fc_in     = rsp_fc_ff;
      rsp_rlen_in   = rsp_rlen_ff;
      rsp_val_in    = rsp_val_ff;
      mem_we        = 1'b0;
      unique case (state_ff)
         tlvrse_pkg::S_IDLE: begin
            if (req_valid) begin
               type_in    = req_type;
               restart_in = req_load_restart;
               byte_in    = req_load_byte;
               tag_in     = req_tag_id;
               cursor_in  = req_cursor;
               bidx_in    = req_byte_index;
            end
         end
         tlvrse_pkg::S_DECODE: begin
            w_status_in = 1'b1;
            w_fc_in     = '1;
            w_rlen_in   = '0;
            w_val_in    = '0;
            skip_in     = 1'b0;
            hcnt_in     = '0;
            case (type_ff)
               tlvrse_pkg::REQ_LOAD: begin
                  mem_we      = load_ok;
                  blob_len_in = load_ok ? (load_base + LEN_W'(1)) : load_base;
                  w_status_in = !load_ok;
                  w_val_in    = 64'(blob_len_in);
               end
               tlvrse_pkg::REQ_FIND_FIRST, tlvrse_pkg::REQ_VALUE: begin
                  off_in = '0;
               end
               tlvrse_pkg::REQ_FIND_AFTER: begin
                  off_in  = cur_pos;
                  skip_in = 1'b1;
               end
               default: begin
                  off_in = cur_pos;
               end
            endcase
         end
         tlvrse_pkg::S_WCHK: begin
            hcnt_in = '0;
         end
         tlvrse_pkg::S_HRD: begin
         end
         tlvrse_pkg::S_HCAP: begin
            hdr_in  = {rd_data_ff, hdr_ff[31:8]};
            hcnt_in = hcnt_ff + 2'd1;
         end
         tlvrse_pkg::S_HEVAL: begin
            hcnt_in = '0;
            if (walk_type) begin
               if (skip_ff) begin
                  off_in  = rec_end;
                  skip_in = 1'b0;
               end else if (rid == end_id_ff) begin
                  w_status_in = 1'b1;
               end else if (rid == tag_ff) begin
                  w_fc_in    = off_ff[CUR_W-1:0];
                  w_rlen_in  = rlen;
                  pay_ptr_in = pay_base;
                  pay_cnt_in = '0;
                  if (type_ff != tlvrse_pkg::REQ_VALUE) w_status_in = 1'b0;
               end else begin
                  off_in = rec_end;
               end
            end else if (type_ff == tlvrse_pkg::REQ_LENGTH) begin
               w_status_in = 1'b0;
               w_fc_in     = off_ff[CUR_W-1:0];
               w_rlen_in   = rlen;
            end else if (type_ff == tlvrse_pkg::REQ_PAYLOAD) begin
               w_rlen_in  = rlen;
               pay_ptr_in = bidx_addr;
            end else begin
               w_rlen_in  = rlen;
               pay_ptr_in = pay_base;
               pay_cnt_in = '0;
            end
         end
         tlvrse_pkg::S_PRD: begin
         end
         tlvrse_pkg::S_PCAP: begin
            case (type_ff)
               tlvrse_pkg::REQ_STRING: begin
                  if (rd_data_ff == 8'd0) begin
                     w_status_in = 1'b0;
                     w_fc_in     = off_ff[CUR_W-1:0];
                  end else begin
                     pay_ptr_in = pay_ptr_ff + OFF_W'(1);
                     pay_cnt_in = pay_cnt_ff + 16'd1;
                  end
               end
               tlvrse_pkg::REQ_VALUE: begin
                  w_val_in[{pay_cnt_ff[2:0], 3'b000} +: 8] = rd_data_ff;
                  pay_ptr_in = pay_ptr_ff + OFF_W'(1);
                  pay_cnt_in = pay_cnt_ff + 16'd1;
                  if (pay_last) w_status_in = 1'b0;
               end
               default: begin
                  w_val_in    = 64'(rd_data_ff);
                  w_status_in = 1'b0;
                  w_fc_in     = off_ff[CUR_W-1:0];
               end
            endcase
         end
         tlvrse_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = w_status_ff;
               rsp_fc_in     = w_fc_ff;
               rsp_rlen_in   = w_rlen_ff;
               rsp_val_in    = w_val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_q[load_base[ADDR_W-1:0]] <= byte_ff;
      rd_data_ff <= mem_q[rd_addr_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlvrse_pkg::S_IDLE;
         blob_len_ff  <= '0;
         end_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blob_len_ff  <= blob_len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) end_id_ff <= csr_end_marker_id;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      restart_ff    <= restart_in;
      byte_ff       <= byte_in;
      tag_ff        <= tag_in;
      cursor_ff     <= cursor_in;
      bidx_ff       <= bidx_in;
      off_ff        <= off_in;
      skip_ff       <= skip_in;
      hcnt_ff       <= hcnt_in;
      hdr_ff        <= hdr_in;
      pay_ptr_ff    <= pay_ptr_in;
      pay_cnt_ff    <= pay_cnt_in;
      w_status_ff   <= w_status_in;
      w_fc_ff       <= w_fc_in;
      w_rlen_ff     <= w_rlen_in;
      w_val_ff      <= w_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fc_ff     <= rsp_fc_in;
      rsp_rlen_ff   <= rsp_rlen_in;
      rsp_val_ff    <= rsp_val_in;
   end

   assign req_stall         = state_ff != tlvrse_pkg::S_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_cursor  = rsp_fc_ff;
   assign rsp_record_length = rsp_rlen_ff;
   assign rsp_value         = rsp_val_ff;

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      blob_len_ff <= LEN_W'(tlvrse_pkg::BLOB_BYTES))
      else $error("blob length beyond store size");

   a_hdr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlvrse_pkg::S_HRD) |-> (hdr_addr < len_x))
      else $error("header read past loaded length");

   a_pay_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlvrse_pkg::S_PCAP) |-> ($past(pay_ptr_ff) < len_x))
      else $error("payload read past loaded length");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == tlvrse_pkg::S_DONE))
      else $error("response raised outside completion");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// TLV record search engine testbench
// Loads record images byte by byte and queries them with finds, length,
// payload byte, string and value reads. Each accepted request is run through
// an in-bench model of the record store, and every response is compared with
// the oldest outstanding prediction. A short directed table comes first, then
// random images under several end-marker settings, random idles on both
// channels and one long response hold.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CUR_W        = tlvrse_pkg::CUR_W;
   localparam int BLOB_BYTES   = tlvrse_pkg::BLOB_BYTES;
   localparam int HDR_BYTES    = tlvrse_pkg::HDR_BYTES;
   localparam logic [2:0] REQ_UNKNOWN = 3'd7;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 225;
   localparam int HOLD_AT      = 600;
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [2:0]              kind;
      logic                    restart;
      logic [7:0]              data;
      logic [15:0]             tag;
      logic signed [CUR_W-1:0] cur;
      logic [15:0]             idx;
   } query_type;

   typedef struct packed {
      logic                    status;
      logic signed [CUR_W-1:0] cursor;
      logic [15:0]             length;
      logic [63:0]             value;
   } answer_type;

   typedef struct packed {
      query_type  q;
      logic       typed;
      answer_type a;
   } row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [2:0]              req_type;
   logic                    req_load_restart;
   logic [7:0]              req_load_byte;
   logic [15:0]             req_tag_id;
   logic signed [CUR_W-1:0] req_cursor;
   logic [15:0]             req_byte_index;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_status;
   logic signed [CUR_W-1:0] rsp_found_cursor;
   logic [15:0]             rsp_record_length;
   logic [63:0]             rsp_value;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [15:0]             csr_end_marker_id;

   logic [7:0]  shadow [BLOB_BYTES];
   int unsigned stored_len = 0;
   logic [15:0] end_id = 16'h0000;

   answer_type  pending_answers [$];
   row_type     directed_rows [$];
   logic [7:0]  image [$];
   int unsigned heads [$];
   logic [15:0] id_pool [4];
   int unsigned sent = 0;
   int unsigned failures = 0;
   bit          quiet = 0;
   bit          rsp_holding = 0;
   bit          hold_done = 0;

   tlv_record_search_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_load_restart  (req_load_restart),
      .req_load_byte     (req_load_byte),
      .req_tag_id        (req_tag_id),
      .req_cursor        (req_cursor),
      .req_byte_index    (req_byte_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_cursor  (rsp_found_cursor),
      .rsp_record_length (rsp_record_length),
      .rsp_value         (rsp_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_end_marker_id (csr_end_marker_id)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int unsigned rd8(input int unsigned addr);
      return (addr < stored_len) ? int'(shadow[addr]) : 0;
   endfunction

   function automatic int unsigned rd16(input int unsigned addr);
      return rd8(addr) | (rd8(addr + 1) << 8);
   endfunction

   function automatic bit header_fits(input logic [CUR_W-1:0] c, output int unsigned at);
      at = c;
      return !c[CUR_W-1] && (at + HDR_BYTES <= stored_len);
   endfunction

   function automatic bit seek_record(input int unsigned from, input logic [15:0] id,
                                      output int unsigned at);
      int unsigned off;
      off = from;
      at = 0;
      while (off + HDR_BYTES <= stored_len) begin
         if (rd16(off) == end_id) return 0;
         if (rd16(off) == id) begin
            at = off;
            return 1;
         end
         off += HDR_BYTES + rd16(off + 2);
      end
      return 0;
   endfunction

   function automatic answer_type predict(input query_type q);
      answer_type  a;
      int unsigned pos;
      int unsigned start;
      int unsigned len;
      int unsigned i;
      bit          go;
      a.status = 1'b1;
      a.cursor = '1;
      a.length = '0;
      a.value  = '0;
      case (q.kind)
         tlvrse_pkg::REQ_LOAD: begin
            if (q.restart) stored_len = 0;
            if (stored_len < BLOB_BYTES) begin
               shadow[stored_len] = q.data;
               stored_len++;
               a.status = 1'b0;
            end
            a.value = 64'(stored_len);
         end
         tlvrse_pkg::REQ_FIND_FIRST, tlvrse_pkg::REQ_FIND_AFTER: begin
            go = 1;
            start = 0;
            if (q.kind == tlvrse_pkg::REQ_FIND_AFTER) begin
               if (header_fits(q.cur, pos)) start = pos + HDR_BYTES + rd16(pos + 2);
               else go = 0;
            end
            if (go && seek_record(start, q.tag, pos)) begin
               a.status = 1'b0;
               a.cursor = CUR_W'(pos);
               a.length = 16'(rd16(pos + 2));
            end
         end
         tlvrse_pkg::REQ_LENGTH, tlvrse_pkg::REQ_PAYLOAD, tlvrse_pkg::REQ_STRING: begin
            if (header_fits(q.cur, pos)) begin
               len = rd16(pos + 2);
               a.length = 16'(len);
               if (q.kind == tlvrse_pkg::REQ_LENGTH) begin
                  a.status = 1'b0;
               end else if (q.kind == tlvrse_pkg::REQ_PAYLOAD) begin
                  if (q.idx < len && pos + HDR_BYTES + q.idx < stored_len) begin
                     a.value = 64'(rd8(pos + HDR_BYTES + q.idx));
                     a.status = 1'b0;
                  end
               end else begin
                  for (i = 0; i < len && pos + HDR_BYTES + i < stored_len; i++) begin
                     if (rd8(pos + HDR_BYTES + i) == 0) begin
                        a.status = 1'b0;
                        break;
                     end
                  end
               end
               if (a.status == 1'b0) a.cursor = CUR_W'(pos);
            end
         end
         tlvrse_pkg::REQ_VALUE: begin
            if (seek_record(0, q.tag, pos)) begin
               a.cursor = CUR_W'(pos);
               len = rd16(pos + 2);
               a.length = 16'(len);
               if ((len == 4 || len == 8) && pos + HDR_BYTES + len <= stored_len) begin
                  for (i = len; i > 0; i--) a.value = (a.value << 8) | 64'(rd8(pos + 3 + i));
                  a.status = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic row_type make_row(input logic [2:0] kind, input logic restart,
                                        input logic [7:0] data, input logic [15:0] tag,
                                        input int cur, input logic [15:0] idx,
                                        input logic typed, input logic status,
                                        input int fcur, input logic [15:0] len,
                                        input logic [63:0] val);
      row_type r;
      r.q = '{kind, restart, data, tag, CUR_W'(cur), idx};
      r.typed = typed;
      r.a = '{status, CUR_W'(fcur), len, val};
      return r;
   endfunction

   task automatic issue(input query_type q, input logic typed, input answer_type a);
      answer_type predicted;
      if (!quiet && !rsp_holding && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= q.kind;
      req_load_restart <= q.restart;
      req_load_byte    <= q.data;
      req_tag_id       <= q.tag;
      req_cursor       <= q.cur;
      req_byte_index   <= q.idx;
      do @(posedge clock); while (req_stall);
      predicted = predict(q);
      pending_answers.push_back(typed ? a : predicted);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic set_end_marker(input logic [15:0] id);
      csr_valid         <= 1'b1;
      csr_end_marker_id <= id;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      end_id = id;
   endtask

   task automatic build_image(input bit append);
      int unsigned base;
      int unsigned nrec;
      int unsigned id;
      int unsigned len;
      int unsigned body;
      int unsigned r;
      image.delete();
      heads.delete();
      base = append ? stored_len : 0;
      nrec = $urandom_range(0, 5);
      r = 0;
      while (r < nrec) begin
         id = id_pool[$urandom_range(0, 3)];
         case ($urandom_range(0, 9))
            0:       len = 0;
            1, 2:    len = 4;
            3, 4:    len = 8;
            5:       len = $urandom_range(0, 16'hFFFF);
            default: len = $urandom_range(1, 12);
         endcase
         body = (len > 12) ? $urandom_range(0, 6) : len;
         heads.push_back(base + image.size());
         image.push_back(8'(id));
         image.push_back(8'(id >> 8));
         image.push_back(8'(len));
         image.push_back(8'(len >> 8));
         repeat (body) image.push_back(($urandom_range(0, 5) == 0) ? 8'h00 :
                                       8'($urandom_range(1, 255)));
         r++;
      end
      if (image.size() > 4 && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) void'(image.pop_back());
      end
   endtask

   task automatic load_image(input bit append);
      query_type q;
      foreach (image[i]) begin
         q.kind    = tlvrse_pkg::REQ_LOAD;
         q.restart = (i == 0) && !append;
         q.data    = image[i];
         q.tag     = 16'($urandom);
         q.cur     = CUR_W'($urandom);
         q.idx     = 16'($urandom);
         issue(q, 1'b0, '0);
      end
   endtask

   task automatic random_query();
      query_type   q;
      int unsigned pick;
      q.kind    = 3'($urandom_range(1, 6));
      q.restart = 1'($urandom);
      q.data    = 8'($urandom);
      q.tag     = 16'($urandom);
      q.cur     = CUR_W'($urandom);
      q.idx     = 16'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         q.kind = REQ_UNKNOWN;
      end else if (pick == 1) begin
         q.kind = tlvrse_pkg::REQ_LOAD;
         q.restart = ($urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 4) != 0) q.tag = id_pool[$urandom_range(0, 3)];
      pick = $urandom_range(0, 9);
      if (heads.size() != 0 && pick < 7) begin
         q.cur = CUR_W'(heads[$urandom_range(0, heads.size() - 1)]);
      end else if (pick == 7) begin
         q.cur = '1;
      end else if (heads.size() != 0 && pick == 8) begin
         q.cur = CUR_W'(heads[$urandom_range(0, heads.size() - 1)] + $urandom_range(1, 3));
      end
      if ($urandom_range(0, 3) != 0) q.idx = 16'($urandom_range(0, 12));
      issue(q, 1'b0, '0);
   endtask

   initial begin : rsp_pacing
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && sent >= HOLD_AT) begin
            hold_done = 1;
            rsp_holding = 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_holding = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected transaction: st=%0d cur=%0d len=%0d val=%h",
                        rsp_status, rsp_found_cursor, rsp_record_length, rsp_value);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_found_cursor !== want.cursor ||
                rsp_record_length !== want.length || rsp_value !== want.value) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("mismatch: exp %0d %0d %0d %h, got %0d %0d %0d %h",
                           want.status, want.cursor, want.length, want.value, rsp_status,
                           rsp_found_cursor, rsp_record_length, rsp_value);
            end
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int unsigned start;
      bit          append;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_type          <= tlvrse_pkg::REQ_LOAD;
      req_load_restart  <= 1'b0;
      req_load_byte     <= '0;
      req_tag_id        <= '0;
      req_cursor        <= '0;
      req_byte_index    <= '0;
      csr_valid         <= 1'b0;
      csr_end_marker_id <= '0;

      directed_rows.push_back(make_row(tlvrse_pkg::REQ_FIND_FIRST, 0, 8'h00, 16'h1234, 0,
                                       16'h0000, 1, 1, -1, 16'd0, 64'd0));
      directed_rows.push_back(make_row(REQ_UNKNOWN, 1, 8'hFF, 16'hFFFF, 0,
                                       16'hFFFF, 1, 1, -1, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LENGTH, 0, 8'h00, 16'h0000, -1,
                                       16'h0000, 1, 1, -1, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 1, 8'hFF, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd1));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 0, 8'hFF, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd2));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 0, 8'h04, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd3));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 0, 8'h00, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd4));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 0, 8'h00, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd5));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 0, 8'h80, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd6));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 0, 8'h7F, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd7));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 0, 8'hFF, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd8));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_VALUE, 0, 8'h00, 16'hFFFF, 0,
                                       16'h0000, 0, 0, 0, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_STRING, 0, 8'h00, 16'h0000, 0,
                                       16'h0000, 0, 0, 0, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_PAYLOAD, 0, 8'h00, 16'h0000, 0,
                                       16'h0003, 0, 0, 0, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_PAYLOAD, 0, 8'h00, 16'h0000, 0,
                                       16'h0004, 1, 1, -1, 16'd4, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_PAYLOAD, 0, 8'h00, 16'h0000, 0,
                                       16'hFFFF, 1, 1, -1, 16'd4, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_FIND_AFTER, 0, 8'h00, 16'hFFFF, 0,
                                       16'h0000, 0, 0, 0, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LENGTH, 0, 8'h00, 16'h0000, 4095,
                                       16'h0000, 1, 1, -1, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LENGTH, 0, 8'h00, 16'h0000, -4096,
                                       16'h0000, 1, 1, -1, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LENGTH, 0, 8'h00, 16'h0000, 5,
                                       16'h0000, 1, 1, -1, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_FIND_FIRST, 0, 8'h00, 16'h0000, 0,
                                       16'h0000, 0, 0, 0, 16'd0, 64'd0));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_LOAD, 1, 8'h00, 16'h0000, 0,
                                       16'h0000, 1, 0, -1, 16'd0, 64'd1));
      directed_rows.push_back(make_row(tlvrse_pkg::REQ_STRING, 0, 8'h00, 16'h0000, 0,
                                       16'h0000, 1, 1, -1, 16'd0, 64'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].a);

      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0:       set_end_marker(16'hFFFF);
            1:       set_end_marker(16'h0000);
            default: set_end_marker(16'($urandom));
         endcase
         id_pool[0] = 16'h0000;
         id_pool[1] = 16'hFFFF;
         id_pool[2] = 16'($urandom);
         id_pool[3] = ($urandom_range(0, 1) == 0) ? end_id : 16'($urandom);
         start = sent;
         while (sent - start < PHASE_ITEMS) begin
            quiet = (phase == PHASES - 1) && (sent - start + 150 > PHASE_ITEMS);
            append = ($urandom_range(0, 7) == 0);
            build_image(append);
            load_image(append);
            repeat ($urandom_range(2, 8)) random_query();
         end
      end

      drain();
      repeat (64) @(posedge clock);
      if (failures == 0 && pending_answers.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
